>>> rtl/core/slcd_pkg.sv
// Shared types, constants and the bytewise CRC-32 step for the sync/length/CRC deframer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package slcd_pkg;

   localparam int unsigned MAX_BUFFER = 16384;

   localparam logic [23:0] SYNC_WORD  = 24'hAA4412;
   localparam logic [16:0] HEADER_LEN = 17'd28;
   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

   // Reset value of the length limit: the buffer less the four CRC bytes.
   localparam logic [16:0] MAX_LEN_RESET = 17'(MAX_BUFFER - 4);

   // Frame status codes.
   localparam logic [2:0] ST_BUSY     = 3'd0;
   localparam logic [2:0] ST_GOOD     = 3'd1;
   localparam logic [2:0] ST_CRC_ERR  = 3'd2;
   localparam logic [2:0] ST_LEN_ERR  = 3'd3;
   localparam logic [2:0] ST_WEEK_ERR = 3'd4;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic [16:0] byte_offset;
      logic        last;
      logic [2:0]  status;
      logic [15:0] message_id;
      logic [16:0] message_length;
   } slcd_result_type;

   // Reflected CRC-32, one byte, no final inversion.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'b0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // CRC state just after the three sync bytes.
   localparam logic [31:0] SYNC_CRC = crc_byte(crc_byte(crc_byte(32'h0, 8'hAA), 8'h44), 8'h12);

endpackage

`default_nettype wire

>>> rtl/core/slcd_frame_core.sv
// Frame state and the combinational step: sync hunt, header capture, CRC and trailer check.
// Depends on slcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slcd_frame_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [16:0]               csr_wdata,
   input  wire logic                      step,
   input  wire logic [7:0]                data_byte,
   output logic                           has_result,
   output slcd_pkg::slcd_result_type      result
);
   import slcd_pkg::*;

   logic [16:0] max_len_ff;
   logic [23:0] history_ff, history_in;
   logic        in_frame_ff, in_frame_in;
   logic [16:0] count_ff, count_in;
   logic [16:0] length_ff, length_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] trailer_ff, trailer_in;
   logic [15:0] type_ff, type_in;
   logic [15:0] week_ff, week_in;

   logic [23:0] history_shift;
   logic [16:0] trail_pos;
   logic        abort, frame_end, last;
   logic [2:0]  status;

   always_comb begin
      history_shift = {history_ff[15:0], data_byte};
      history_in    = history_ff;
      in_frame_in   = in_frame_ff;
      count_in      = count_ff;
      length_in     = length_ff;
      crc_in        = crc_ff;
      trailer_in    = trailer_ff;
      type_in       = type_ff;
      week_in       = week_ff;
      trail_pos     = count_ff - length_ff;
      abort         = 1'b0;
      frame_end     = 1'b0;
      last          = 1'b0;
      status        = ST_BUSY;

      if (!in_frame_ff) begin
         // The history only moves while hunting.
         history_in = history_shift;
         if (history_shift == SYNC_WORD) begin
            in_frame_in = 1'b1;
            count_in    = 17'd3;
            length_in   = 17'd0;
            crc_in      = SYNC_CRC;
            trailer_in  = 32'h0;
            type_in     = 16'h0;
            week_in     = 16'h0;
         end
      end else begin
         if (count_ff == 17'd4)  type_in = {type_ff[15:8], data_byte};
         if (count_ff == 17'd5)  type_in = {data_byte, type_ff[7:0]};
         if (count_ff == 17'd14) week_in = {week_ff[15:8], data_byte};
         if (count_ff == 17'd15) week_in = {data_byte, week_ff[7:0]};
         if (count_ff == 17'd8)  length_in = {9'b0, data_byte};
         if (count_ff == 17'd9)  length_in = {1'b0, data_byte, length_ff[7:0]} + HEADER_LEN;

         if (count_ff < 17'd10 || count_ff < length_ff) begin
            crc_in = crc_byte(crc_ff, data_byte);
         end else if (trail_pos < 17'd4) begin
            for (int k = 0; k < 4; k++) begin
               if (trail_pos[1:0] == 2'(k)) begin
                  trailer_in[8*k +: 8] = trailer_ff[8*k +: 8] | data_byte;
               end
            end
         end

         abort = (count_ff == 17'd9) && (length_in > max_len_ff);
         frame_end = !abort && (count_ff >= 17'd9) &&
                     (({1'b0, count_ff} + 18'd1) >= ({1'b0, length_in} + 18'd4));
         last = abort || frame_end;

         if (abort) begin
            status = ST_LEN_ERR;
         end else if (frame_end) begin
            if (crc_in != trailer_in) begin
               status = ST_CRC_ERR;
            end else if (week_in == 16'h0) begin
               status = ST_WEEK_ERR;
            end else begin
               status = ST_GOOD;
            end
         end

         if (last) begin
            in_frame_in = 1'b0;
            count_in    = 17'd0;
         end else begin
            count_in    = count_ff + 17'd1;
         end
      end
   end

   assign has_result            = in_frame_ff;
   assign result.frame_byte     = data_byte;
   assign result.byte_offset    = count_ff;
   assign result.last           = last;
   assign result.status         = status;
   assign result.message_id     = type_in;
   assign result.message_length = (count_ff >= 17'd9) ? length_in : 17'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff  <= MAX_LEN_RESET;
         history_ff  <= 24'h0;
         in_frame_ff <= 1'b0;
         count_ff    <= 17'd0;
         length_ff   <= 17'd0;
         crc_ff      <= 32'h0;
         trailer_ff  <= 32'h0;
         type_ff     <= 16'h0;
         week_ff     <= 16'h0;
      end else begin
         if (csr_we) begin
            max_len_ff <= csr_wdata;
         end
         if (step) begin
            history_ff  <= history_in;
            in_frame_ff <= in_frame_in;
            count_ff    <= count_in;
            length_ff   <= length_in;
            crc_ff      <= crc_in;
            trailer_ff  <= trailer_in;
            type_ff     <= type_in;
            week_ff     <= week_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sync_length_crc_deframer.sv
// Top level of the sync/length/CRC deframer: input register, frame core and result register.
// Depends on slcd_pkg and slcd_frame_core.
//
// Usage: raw receiver bytes enter on the req_ channel, one byte per transfer. While hunting,
// the block looks for the sync sequence AA 44 12; hunting bytes and the sync bytes give no
// result. Every later byte of a locked frame leaves on the rsp_ channel with its offset from
// the first sync byte, the message id and length as far as known, and on the closing byte
// last=1 and the frame status (good, CRC mismatch, length too large or zero week).
// Header-plus-body length limit via csr_we/csr_wdata; write only while idle (not enforced).
// Path: a byte accepted into the input register is processed by the frame core when it can
// advance, and its result is loaded into the result register, from which it transfers on
// the rsp_ channel.
// Throughput: one byte per cycle unless the receiver stalls; the CRC byte step, counters and
// compares of the frame core all sit between the input register and the result register.
// Reset: the block hunts, both registers are empty and the limit returns to 16380.
// When the receiver stalls, the result is held; the input register takes one more byte if it
// is empty, and req_stall is high while it holds a byte, until the result transfer completes.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_crc_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [16:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_frame_byte,
   output logic [16:0]      rsp_byte_offset,
   output logic             rsp_last,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_message_id,
   output logic [16:0]      rsp_message_length
);
   import slcd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff, out_valid_in;
   slcd_result_type out_ff;

   logic            out_free, advance, load, has_result;
   slcd_result_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign load      = req_valid && !req_stall;

   slcd_frame_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .step       (advance),
      .data_byte  (in_byte_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance && has_result) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_byte     = out_ff.frame_byte;
   assign rsp_byte_offset    = out_ff.byte_offset;
   assign rsp_last           = out_ff.last;
   assign rsp_status         = out_ff.status;
   assign rsp_message_id     = out_ff.message_id;
   assign rsp_message_length = out_ff.message_length;

   // A frame only closes with a final status, and a status only comes with the closing byte.
   a_last_has_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_status != ST_BUSY)
      else $error("closing byte without a final status");

   a_busy_not_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == ST_BUSY)
      else $error("final status on a byte that does not close the frame");

   // Sync bytes never leave the block, so no offset below 3 is ever sent.
   a_offset_floor : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_offset >= 17'd3)
      else $error("result offset inside the sync sequence");

   // A held byte in the input register is not dropped while the output is blocked.
   a_input_held : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && req_stall |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input register lost a byte during a stall");

endmodule

`default_nettype wire
